// ===== hdl/ahrfd_pkg.sv =====
// shared types, constants and helpers for the ascii hex reply frame decoder
`default_nettype none

package ahrfd_pkg;

   // default number of index positions in one frame; the store keeps the first 18
   localparam int FRAME_CHARS_DEF = 32;

   // slots that the decode reads: ten header digits and up to eight value digits
   localparam int DECODE_CHARS = 18;
   localparam int DECODE_BYTES = DECODE_CHARS / 2;

   // width and ceiling of the reported character count
   localparam int COUNT_W   = 5;
   localparam int COUNT_MAX = 2 ** COUNT_W - 1;

   // framing characters
   localparam logic [7:0] CH_START = 8'h3A;
   localparam logic [7:0] CH_END   = 8'h0D;

   // process / parameter pairs that select a kind
   localparam logic [7:0] PROC_MODE_MEAS = 8'h01;
   localparam logic [7:0] PROC_FLOW_TEMP = 8'h21;
   localparam logic [7:0] PROC_DENSITY   = 8'h74;
   localparam logic [7:0] PROC_VALVE     = 8'h72;
   localparam logic [7:0] PROC_SERIAL    = 8'h71;
   localparam logic [7:0] PAR_MODE       = 8'h04;
   localparam logic [7:0] PAR_MEAS       = 8'h21;
   localparam logic [7:0] PAR_FLOW       = 8'h40;
   localparam logic [7:0] PAR_TEMP       = 8'h47;
   localparam logic [7:0] PAR_DENSITY    = 8'h4F;
   localparam logic [7:0] PAR_VALVE      = 8'h41;
   localparam logic [7:0] PAR_SERIAL     = 8'h63;

   // kind codes
   localparam logic [2:0] KIND_OTHER   = 3'd0;
   localparam logic [2:0] KIND_MODE    = 3'd1;
   localparam logic [2:0] KIND_MEAS    = 3'd2;
   localparam logic [2:0] KIND_FLOW    = 3'd3;
   localparam logic [2:0] KIND_TEMP    = 3'd4;
   localparam logic [2:0] KIND_DENSITY = 3'd5;
   localparam logic [2:0] KIND_VALVE   = 3'd6;
   localparam logic [2:0] KIND_SERIAL  = 3'd7;

   // the decoded slots of one frame, slot 0 in the lowest byte
   typedef logic [DECODE_CHARS-1:0][7:0] chars_type;

   // one decoded reply
   typedef struct packed {
      logic [7:0]         msg_length;
      logic [7:0]         node_addr;
      logic [7:0]         command_code;
      logic [7:0]         process_num;
      logic [7:0]         param_code;
      logic [2:0]         kind;
      logic [31:0]        value_bits;
      logic               write_ack;
      logic               hex_error;
      logic [COUNT_W-1:0] char_count;
   } result_type;

   // hex character to nibble, top bit flags a non-hex character
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b0, 4'(c[3:0] + 4'd9)};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ahrfd_decode.sv =====
// combinational decode of the stored frame characters into one reply
`default_nettype none

module ahrfd_decode (
   input  wire ahrfd_pkg::chars_type                 chars,
   input  wire logic [ahrfd_pkg::COUNT_W-1:0]        count,
   output ahrfd_pkg::result_type                     result
);

   logic [ahrfd_pkg::DECODE_CHARS-1:0][3:0] nib;
   logic [ahrfd_pkg::DECODE_CHARS-1:0]      bad;
   logic [ahrfd_pkg::DECODE_BYTES-1:0][7:0] byte_val;
   logic                                    hdr_bad;
   logic [7:0]                              proc;
   logic [7:0]                              par;

   // every digit converted in parallel
   for (genvar i = 0; i < ahrfd_pkg::DECODE_CHARS; i++) begin : g_digit
      assign {bad[i], nib[i]} = ahrfd_pkg::hex_nibble(chars[i]);
   end

   // digit pairs, high nibble first
   for (genvar b = 0; b < ahrfd_pkg::DECODE_BYTES; b++) begin : g_byte
      assign byte_val[b] = {nib[2*b], nib[2*b+1]};
   end

   assign hdr_bad = |bad[9:0];
   assign proc    = byte_val[3];
   assign par     = byte_val[4];

   // kind select and big-endian value assembly
   always_comb begin
      result              = '0;
      result.msg_length   = byte_val[0];
      result.node_addr    = byte_val[1];
      result.command_code = byte_val[2];
      result.process_num  = proc;
      result.param_code   = par;
      result.write_ack    = (byte_val[2] == 8'h00) && (proc == 8'h00);
      result.char_count   = count;
      result.hex_error    = hdr_bad;
      if (proc == ahrfd_pkg::PROC_MODE_MEAS && par == ahrfd_pkg::PAR_MODE) begin
         result.kind       = ahrfd_pkg::KIND_MODE;
         result.value_bits = {24'h0, byte_val[5]};
         result.hex_error  = hdr_bad | (|bad[11:10]);
      end else if (proc == ahrfd_pkg::PROC_MODE_MEAS && par == ahrfd_pkg::PAR_MEAS) begin
         result.kind       = ahrfd_pkg::KIND_MEAS;
         result.value_bits = {16'h0, byte_val[5], byte_val[6]};
         result.hex_error  = hdr_bad | (|bad[13:10]);
      end else if ((proc == ahrfd_pkg::PROC_FLOW_TEMP && par == ahrfd_pkg::PAR_FLOW)
                || (proc == ahrfd_pkg::PROC_FLOW_TEMP && par == ahrfd_pkg::PAR_TEMP)
                || (proc == ahrfd_pkg::PROC_DENSITY && par == ahrfd_pkg::PAR_DENSITY)
                || (proc == ahrfd_pkg::PROC_VALVE && par == ahrfd_pkg::PAR_VALVE)) begin
         if (proc == ahrfd_pkg::PROC_DENSITY) begin
            result.kind = ahrfd_pkg::KIND_DENSITY;
         end else if (proc == ahrfd_pkg::PROC_VALVE) begin
            result.kind = ahrfd_pkg::KIND_VALVE;
         end else if (par == ahrfd_pkg::PAR_FLOW) begin
            result.kind = ahrfd_pkg::KIND_FLOW;
         end else begin
            result.kind = ahrfd_pkg::KIND_TEMP;
         end
         result.value_bits = {byte_val[5], byte_val[6], byte_val[7], byte_val[8]};
         result.hex_error  = hdr_bad | (|bad[17:10]);
      end else if (proc == ahrfd_pkg::PROC_SERIAL && par == ahrfd_pkg::PAR_SERIAL) begin
         result.kind = ahrfd_pkg::KIND_SERIAL;
      end else begin
         result.kind = ahrfd_pkg::KIND_OTHER;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ascii_hex_reply_frame_decoder_unit.sv =====
// Received serial characters arrive one per transaction on the req_ channel.
// A ':' outside a frame opens a frame; inside a frame each character other
// than carriage return advances the index (saturating at the last slot) and,
// while the index is below 18, goes into the character store; a carriage
// return closes the frame and gives one decoded reply on the rsp_ channel.
// Other characters give no reply. The decode is one pass of logic from the
// store to the result register, or to the skid register under a stalled reply.
// Throughput: one character per cycle, every cycle, while replies drain.
// The result register is backed by one skid register, so the block keeps
// taking characters while a reply waits under rsp_stall; req_stall rises
// only when both hold replies, and drops once the receiver takes one.
// Reset (synchronous, active high) leaves the block outside a frame with an
// empty output and a zeroed store; slots that a short frame does not write
// keep the characters of earlier frames.
`default_nettype none

module ascii_hex_reply_frame_decoder_unit #(
   parameter int FRAME_CHARS = ahrfd_pkg::FRAME_CHARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_msg_length,
   output logic [7:0]       rsp_node_addr,
   output logic [7:0]       rsp_command_code,
   output logic [7:0]       rsp_process_num,
   output logic [7:0]       rsp_param_code,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_value_bits,
   output logic             rsp_write_ack,
   output logic             rsp_hex_error,
   output logic [4:0]       rsp_char_count
);

   localparam int IDX_W = $clog2(FRAME_CHARS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(FRAME_CHARS - 1);
   localparam logic [IDX_W-1:0] COUNT_TOP = IDX_W'(ahrfd_pkg::COUNT_MAX);

   logic                  in_frame_ff, in_frame_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   ahrfd_pkg::chars_type  store_ff, store_in;
   ahrfd_pkg::result_type out_ff, out_in, skid_ff, skid_in, decoded;
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                  accept, close_frame, out_take;
   logic [ahrfd_pkg::COUNT_W-1:0] count;

   assign req_stall   = skid_valid_ff;
   assign accept      = req_valid && !req_stall;
   assign close_frame = accept && in_frame_ff && (req_rx_byte == ahrfd_pkg::CH_END);
   assign out_take    = out_valid_ff && !rsp_stall;

   // stored count, saturated to the reported width
   assign count = (index_ff > COUNT_TOP) ? ahrfd_pkg::COUNT_W'(ahrfd_pkg::COUNT_MAX)
                                         : index_ff[ahrfd_pkg::COUNT_W-1:0];

   // framing and character store
   always_comb begin
      in_frame_in = in_frame_ff;
      index_in    = index_ff;
      store_in    = store_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == ahrfd_pkg::CH_START) begin
               in_frame_in = 1'b1;
            end
         end else if (req_rx_byte == ahrfd_pkg::CH_END) begin
            in_frame_in = 1'b0;
            index_in    = '0;
         end else begin
            for (int i = 0; i < ahrfd_pkg::DECODE_CHARS; i++) begin
               if (index_ff == IDX_W'(i)) begin
                  store_in[i] = req_rx_byte;
               end
            end
            if (index_ff != LAST_SLOT) begin
               index_in = index_ff + 1'b1;
            end
         end
      end
   end

   ahrfd_decode u_decode (
      .chars  (store_ff),
      .count  (count),
      .result (decoded)
   );

   // result register with one skid entry behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (close_frame) begin
         if (!out_valid_ff || out_take) begin
            out_in       = decoded;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = decoded;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         index_ff      <= '0;
         store_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         index_ff      <= index_in;
         store_ff      <= store_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_msg_length   = out_ff.msg_length;
   assign rsp_node_addr    = out_ff.node_addr;
   assign rsp_command_code = out_ff.command_code;
   assign rsp_process_num  = out_ff.process_num;
   assign rsp_param_code   = out_ff.param_code;
   assign rsp_kind         = out_ff.kind;
   assign rsp_value_bits   = out_ff.value_bits;
   assign rsp_write_ack    = out_ff.write_ack;
   assign rsp_hex_error    = out_ff.hex_error;
   assign rsp_char_count   = out_ff.char_count;

endmodule

`default_nettype wire

// ===== hdl/ahrfd_checker.sv =====
// port-level checks for the frame decoder, bound to the top level
`default_nettype none

module ahrfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_command_code,
   input wire logic [7:0]  rsp_process_num,
   input wire logic [2:0]  rsp_kind,
   input wire logic [31:0] rsp_value_bits,
   input wire logic        rsp_write_ack
);

   // a held reply stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("reply dropped while stalled");

   // a new reply only follows an accepted carriage return
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_rx_byte == ahrfd_pkg::CH_END))
      else $error("reply without closing transaction");

   // input only stalls when the output side is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // kinds without a value report zero
   a_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ahrfd_pkg::KIND_OTHER || rsp_kind == ahrfd_pkg::KIND_SERIAL)
      |-> rsp_value_bits == 32'h0)
      else $error("value on a kind without value");

   // write acknowledge matches the command and process bytes
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_write_ack == (rsp_command_code == 8'h00 && rsp_process_num == 8'h00))
      else $error("write acknowledge mismatch");

endmodule

bind ascii_hex_reply_frame_decoder_unit ahrfd_checker u_ahrfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_command_code (rsp_command_code),
   .rsp_process_num  (rsp_process_num),
   .rsp_kind         (rsp_kind),
   .rsp_value_bits   (rsp_value_bits),
   .rsp_write_ack    (rsp_write_ack)
);

`default_nettype wire
